/* rtl/core/prsc_pkg.sv */
package prsc_pkg;

  localparam int unsigned FieldW = 13;
  localparam int unsigned FirstPrime = 2;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture a new request
    logic init_wr;    // fill one store entry
    logic p_init;     // base prime = 2, square = 4
    logic p_issue;    // read flag of base prime
    logic p_next;     // advance base prime and its square
    logic m_init;     // first multiple = p*p
    logic strike_wr;  // clear one multiple
    logic k_init;     // count pointer = low
    logic cnt_issue;  // read one flag of the range
    logic out_load;   // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;
    logic init_done;
    logic p_done;
    logic flag;
    logic strike_done;
    logic cnt_done;
  } status_t;

endpackage

/* rtl/core/prsc_ram.sv */
module prsc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/prsc_datapath.sv */
module prsc_datapath #(
  parameter int unsigned MAX_N = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prsc_pkg::cmd_t                cmd_i,
  output prsc_pkg::status_t             status_o,
  input  logic [prsc_pkg::FieldW-1:0]   range_low_i,
  input  logic [prsc_pkg::FieldW-1:0]   range_high_i,
  output logic [prsc_pkg::FieldW-1:0]   prime_count_o,
  output logic                          bad_range_o
);

  localparam int unsigned AW = $clog2(MAX_N);
  localparam int unsigned VW = $clog2(MAX_N + 1);
  localparam int unsigned CW = (VW > prsc_pkg::FieldW) ? VW : prsc_pkg::FieldW;
  localparam int unsigned FW = prsc_pkg::FieldW;

  logic [VW-1:0] low_q, low_d, high_q, high_d;
  logic [VW-1:0] k_q, k_d, p_q, p_d;
  logic [VW:0]   sq_q, sq_d, m_q, m_d;
  logic [FW-1:0] count_q, count_d;
  logic          bad_q, bad_d;
  logic          pend_q;
  logic [FW-1:0] out_count_q;
  logic          out_bad_q;

  logic [CW-1:0] low_ext, high_ext;
  logic [VW:0]   high_w;
  logic          we, re, wdata, rdata;
  logic [AW-1:0] waddr, raddr;

  assign low_ext  = CW'(range_low_i);
  assign high_ext = CW'(range_high_i);
  assign high_w   = {1'b0, high_q};

  always_comb begin
    low_d   = low_q;
    high_d  = high_q;
    bad_d   = bad_q;
    k_d     = k_q;
    p_d     = p_q;
    sq_d    = sq_q;
    m_d     = m_q;
    count_d = count_q;
    if (pend_q && rdata) begin
      count_d = count_q + FW'(1);
    end
    if (cmd_i.load) begin
      low_d   = (low_ext > CW'(MAX_N)) ? VW'(MAX_N) : VW'(low_ext);
      high_d  = (high_ext > CW'(MAX_N)) ? VW'(MAX_N) : VW'(high_ext);
      bad_d   = range_low_i > range_high_i;
      k_d     = '0;
      count_d = '0;
    end
    if (cmd_i.init_wr || cmd_i.cnt_issue) begin
      k_d = k_q + VW'(1);
    end
    if (cmd_i.p_init) begin
      p_d  = VW'(prsc_pkg::FirstPrime);
      sq_d = (VW + 1)'(prsc_pkg::FirstPrime * prsc_pkg::FirstPrime);
    end
    if (cmd_i.p_next) begin
      // (p+1)^2 = p^2 + 2p + 1
      p_d  = p_q + VW'(1);
      sq_d = sq_q + {p_q, 1'b1};
    end
    if (cmd_i.m_init) begin
      m_d = sq_q;
    end
    if (cmd_i.strike_wr) begin
      m_d = m_q + {1'b0, p_q};
    end
    if (cmd_i.k_init) begin
      k_d = low_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= '0;
      high_q  <= '0;
      bad_q   <= 1'b0;
      k_q     <= '0;
      p_q     <= '0;
      sq_q    <= '0;
      m_q     <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      low_q   <= low_d;
      high_q  <= high_d;
      bad_q   <= bad_d;
      k_q     <= k_d;
      p_q     <= p_d;
      sq_q    <= sq_d;
      m_q     <= m_d;
      count_q <= count_d;
      pend_q  <= cmd_i.cnt_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_count_q <= count_q;
      out_bad_q   <= bad_q;
    end
  end

  // 0 and 1 are written as non-candidates during the fill
  assign we    = cmd_i.init_wr || cmd_i.strike_wr;
  assign waddr = cmd_i.init_wr ? k_q[AW-1:0] : m_q[AW-1:0];
  assign wdata = cmd_i.init_wr && (k_q >= VW'(prsc_pkg::FirstPrime));
  assign re    = cmd_i.p_issue || cmd_i.cnt_issue;
  assign raddr = cmd_i.p_issue ? p_q[AW-1:0] : k_q[AW-1:0];

  prsc_ram #(
    .Width(1),
    .Depth(MAX_N)
  ) u_flags (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign status_o.bad         = bad_q;
  assign status_o.init_done   = k_q >= high_q;
  assign status_o.p_done      = sq_q >= high_w;
  assign status_o.flag        = rdata;
  assign status_o.strike_done = m_q >= high_w;
  assign status_o.cnt_done    = k_q >= high_q;

  assign prime_count_o = out_count_q;
  assign bad_range_o   = out_bad_q;

endmodule

/* rtl/core/prsc_ctrl.sv */
module prsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  prsc_pkg::status_t status_i,
  output prsc_pkg::cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StCheck  = 8'b0000_0010,
    StInit   = 8'b0000_0100,
    StPTest  = 8'b0000_1000,
    StPRead  = 8'b0001_0000,
    StStrike = 8'b0010_0000,
    StCount  = 8'b0100_0000,
    StFinish = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        state_d = status_i.bad ? StFinish : StInit;
      end
      StInit: begin
        if (status_i.init_done) begin
          cmd_o.p_init = 1'b1;
          state_d      = StPTest;
        end else begin
          cmd_o.init_wr = 1'b1;
        end
      end
      StPTest: begin
        if (status_i.p_done) begin
          cmd_o.k_init = 1'b1;
          state_d      = StCount;
        end else begin
          cmd_o.p_issue = 1'b1;
          state_d       = StPRead;
        end
      end
      StPRead: begin
        if (status_i.flag) begin
          cmd_o.m_init = 1'b1;
          state_d      = StStrike;
        end else begin
          cmd_o.p_next = 1'b1;
          state_d      = StPTest;
        end
      end
      StStrike: begin
        if (status_i.strike_done) begin
          cmd_o.p_next = 1'b1;
          state_d      = StPTest;
        end else begin
          cmd_o.strike_wr = 1'b1;
        end
      end
      StCount: begin
        // last read still lands in the count on this edge
        if (status_i.cnt_done) begin
          state_d = StFinish;
        end else begin
          cmd_o.cnt_issue = 1'b1;
        end
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/prime_range_sieve_counter_unit.sv */
// A request fills the flag store up to the clamped high end, strikes the multiples of
// each base prime whose square lies below that end, then counts the set flags from the
// clamped low end up; a bad range skips the sieve. A new request is taken only when idle,
// once the last result is in the output register; one flag store access a cycle at most.
// Reset (rst_ni, asynchronous, active low) clears control; the flag store is not cleared.
module prime_range_sieve_counter_unit #(
  parameter int unsigned MAX_N = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [12:0] range_low, [25:13] range_high
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [12:0] prime_count
  output logic [0:0]  m_axis_tuser    // [0] bad_range
);

  prsc_pkg::cmd_t              cmd;
  prsc_pkg::status_t           status;
  logic [prsc_pkg::FieldW-1:0] prime_count;
  logic                        bad_range;

  prsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prsc_datapath #(
    .MAX_N(MAX_N)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .range_low_i  (s_axis_tdata[12:0]),
    .range_high_i (s_axis_tdata[25:13]),
    .prime_count_o(prime_count),
    .bad_range_o  (bad_range)
  );

  assign m_axis_tdata = {3'b000, prime_count};
  assign m_axis_tuser = bad_range;

endmodule

/* test/prime_range_sieve_counter_unit_test.sv */
module prime_range_sieve_counter_unit_test;

  localparam int unsigned StoreN       = 4096;
  localparam int unsigned RandomN      = 80;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned CycleLimit   = 1_500_000;

  // one range request as queued for the driver
  typedef struct packed {
    logic [12:0] range_low;
    logic [12:0] range_high;
    logic        drain_first;  // hold off until every answer is back
  } range_req_t;

  typedef struct packed {
    logic [12:0] prime_count;
    logic        bad_range;
  } tally_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [12:0] range_low, [25:13] range_high
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [12:0] prime_count
  logic [0:0]  m_axis_tuser;         // [0] bad_range

  bit          prime_flag [StoreN];
  range_req_t  range_backlog [$];
  tally_t      tally_due [$];
  int unsigned total_n = 0;
  int unsigned answered_n = 0;       // updated by nonblocking assignment only
  int unsigned fail_n = 0;
  int unsigned cycle_n = 0;

  prime_range_sieve_counter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // ends above the store saturate; an inverted raw range flags and counts nothing
  function automatic tally_t tally_range(logic [12:0] lo, logic [12:0] hi);
    tally_t      t;
    int unsigned a;
    int unsigned b;
    t = '0;
    if (lo > hi) begin
      t.bad_range = 1'b1;
      return t;
    end
    a = (lo > StoreN) ? StoreN : lo;
    b = (hi > StoreN) ? StoreN : hi;
    for (int unsigned k = a; k < b; k++) begin
      if (prime_flag[k]) t.prime_count = t.prime_count + 13'd1;
    end
    return t;
  endfunction

  // idle percentages: sender busy-ish first, then receiver, then flat out
  function automatic int unsigned idle_pct(bit sender);
    if (answered_n < total_n / 3) return sender ? 34 : 77;
    if (answered_n < 2 * total_n / 3) return sender ? 77 : 34;
    return 0;
  endfunction

  function automatic range_req_t mk_req(int unsigned lo, int unsigned hi, bit drain);
    range_req_t r;
    r.range_low   = lo[12:0];
    r.range_high  = hi[12:0];
    r.drain_first = drain;
    return r;
  endfunction

  always @(posedge clk_i) begin : drive
    range_req_t  nxt;
    int unsigned sent_n;
    if (s_axis_tvalid && s_axis_tready) begin
      tally_due.push_back(tally_range(s_axis_tdata[12:0], s_axis_tdata[25:13]));
      sent_n++;
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (rst_ni && range_backlog.size() > 0
          && !(range_backlog[0].drain_first && sent_n != answered_n)
          && $urandom_range(99) >= idle_pct(1'b1)) begin
        nxt = range_backlog.pop_front();
        s_axis_tdata  <= {6'd0, nxt.range_high, nxt.range_low};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    tally_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      answered_n <= answered_n + 1;
      if (tally_due.size() == 0) begin
        $error("unexpected result: prime_count %0d bad_range %0d",
               m_axis_tdata[12:0], m_axis_tuser[0]);
        fail_n++;
      end else begin
        want = tally_due.pop_front();
        if (m_axis_tdata[12:0] !== want.prime_count) begin
          $error("prime_count: expected %0d, got %0d", want.prime_count, m_axis_tdata[12:0]);
          fail_n++;
        end
        if (m_axis_tuser[0] !== want.bad_range) begin
          $error("bad_range: expected %0d, got %0d", want.bad_range, m_axis_tuser[0]);
          fail_n++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n == CycleLimit) begin
      $display("prime_range_sieve_counter_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    // plain sieve over the whole store
    for (int unsigned k = 2; k < StoreN; k++) prime_flag[k] = 1'b1;
    for (int unsigned p = 2; p * p < StoreN; p++) begin
      if (prime_flag[p]) begin
        for (int unsigned m = p * p; m < StoreN; m += p) prime_flag[m] = 1'b0;
      end
    end

    // directed: empty, tiny, full, saturated and inverted ranges
    range_backlog.push_back(mk_req(0, 0, 0));
    range_backlog.push_back(mk_req(0, 1, 0));
    range_backlog.push_back(mk_req(0, 2, 0));
    range_backlog.push_back(mk_req(0, 3, 0));
    range_backlog.push_back(mk_req(2, 3, 0));
    range_backlog.push_back(mk_req(2, 2, 0));
    range_backlog.push_back(mk_req(3, 5, 0));
    range_backlog.push_back(mk_req(100, 200, 0));
    range_backlog.push_back(mk_req(1, 0, 0));
    range_backlog.push_back(mk_req(8191, 0, 0));
    range_backlog.push_back(mk_req(8191, 4096, 0));
    range_backlog.push_back(mk_req(4097, 4096, 0));
    range_backlog.push_back(mk_req(0, 4096, 0));
    range_backlog.push_back(mk_req(0, 8191, 0));
    range_backlog.push_back(mk_req(4093, 4096, 0));
    range_backlog.push_back(mk_req(4095, 4096, 0));
    range_backlog.push_back(mk_req(4096, 4096, 0));
    range_backlog.push_back(mk_req(4096, 8191, 0));
    range_backlog.push_back(mk_req(8191, 8191, 0));
    range_backlog.push_back(mk_req(5461, 6826, 0));
    range_backlog.push_back(mk_req(2730, 2731, 0));

    // random: mostly short ranges, a few inverted, a handful reaching the top
    for (int unsigned i = 0; i < RandomN; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        lo = $urandom_range(8191, 1);
        hi = $urandom_range(lo - 1, 0);
      end else if (r < 12) begin
        hi = $urandom_range(8191, 3000);
        lo = $urandom_range(hi, 0);
      end else if (r < 17) begin
        lo = $urandom_range(400, 0);
        hi = lo;
      end else begin
        hi = $urandom_range(400, 0);
        lo = $urandom_range(hi, 0);
      end
      range_backlog.push_back(mk_req(lo, hi, i == 0 || i == RandomN / 2));
    end
    total_n = range_backlog.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (range_backlog.size() > 0 || s_axis_tvalid || tally_due.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (fail_n == 0) begin
      $display("prime_range_sieve_counter_unit regression: pass");
    end else begin
      $display("prime_range_sieve_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/prsc_pkg.sv
rtl/core/prsc_ram.sv
rtl/core/prsc_datapath.sv
rtl/core/prsc_ctrl.sv
rtl/core/prime_range_sieve_counter_unit.sv
test/prime_range_sieve_counter_unit_test.sv
